/* rtl/zigzag_count_matrix_power_top_defines.svh */
// assertion helpers used by the datapath
`ifndef ZIGZAG_COUNT_MATRIX_POWER_TOP_DEFINES_SVH
`define ZIGZAG_COUNT_MATRIX_POWER_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define ZCMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ZCMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/zcmp_pkg.sv */
package zcmp_pkg;

    localparam logic [31:0] PRIME   = 32'd1000000007;
    // floor(2^61 / prime), barrett reciprocal
    localparam logic [31:0] BARRETT_MU = 32'd2305842993;

    // cycles from last mac issue until the scratch write has landed
    localparam logic [3:0] MAC_DRAIN = 4'd8;
    // cycles from last sum read until the total is settled
    localparam logic [3:0] SUM_DRAIN = 4'd2;

    typedef struct packed {
        logic mac_valid;
        logic mac_first;
        logic mac_last;
        logic mac_rp;
        logic copy_valid;
        logic copy_to_p;
        logic init_valid;
        logic init_r_one;
        logic init_p_one;
        logic sum_valid;
        logic sum_first;
        logic total_clear;
        logic out_load;
    } zcmp_cmd_t;

    typedef struct packed {
        logic out_full;
    } zcmp_status_t;

endpackage

/* rtl/zcmp_ctrl.sv */
module zcmp_ctrl
    import zcmp_pkg::*;
#(
    parameter int MAX_VALUES = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [30:0]                   array_length,
    input  logic [6:0]                    value_count,
    input  zcmp_status_t                  status,
    output zcmp_cmd_t                     cmd,
    output logic [$clog2(MAX_VALUES)-1:0] row_idx,
    output logic [$clog2(MAX_VALUES)-1:0] col_idx,
    output logic [$clog2(MAX_VALUES)-1:0] inner_idx
);

    localparam int IW = $clog2(MAX_VALUES);
    localparam logic [IW-1:0] ONE_I = IW'(1);
    localparam logic [7:0] MAX_V = 8'(MAX_VALUES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_COPY   = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_SDRAIN = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [30:0]   exp_reg, exp_next;
    logic [IW-1:0] m_last_reg, m_last_next;
    logic          mode_rp_reg, mode_rp_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [3:0]    cnt_reg, cnt_next;

    logic [7:0]    vc_ext;
    logic [7:0]    vc_sat;
    logic          i_wrap, j_wrap, k_wrap;
    logic [30:0]   exp_half;

    assign vc_ext   = {1'b0, value_count};
    assign vc_sat   = (vc_ext > MAX_V) ? MAX_V : vc_ext;
    assign i_wrap   = (i_reg == m_last_reg);
    assign j_wrap   = (j_reg == m_last_reg);
    assign k_wrap   = (k_reg == m_last_reg);
    assign exp_half = {1'b0, exp_reg[30:1]};

    assign req_stall = (state_reg != S_IDLE);
    assign row_idx   = i_reg;
    assign col_idx   = j_reg;
    assign inner_idx = k_reg;

    always_comb
    begin
        state_next   = state_reg;
        exp_next     = exp_reg;
        m_last_next  = m_last_reg;
        mode_rp_next = mode_rp_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    exp_next    = (array_length == 31'd0) ? 31'd0 : array_length - 31'd1;
                    m_last_next = IW'(vc_sat - 8'd1);
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    if (vc_sat == 8'd0)
                    begin
                        cmd.total_clear = 1'b1;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_valid = 1'b1;
                cmd.init_r_one = (i_reg == j_reg);
                cmd.init_p_one = (({1'b0, i_reg} + {1'b0, j_reg}) > {1'b0, m_last_reg});
                j_next = j_wrap ? '0 : j_reg + ONE_I;
                if (j_wrap)
                begin
                    i_next = i_wrap ? '0 : i_reg + ONE_I;
                    if (i_wrap)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (exp_reg == 31'd0)
                begin
                    state_next = S_SUM;
                end
                else if (exp_reg[0])
                begin
                    mode_rp_next = 1'b1;
                    state_next   = S_MUL;
                end
                else
                begin
                    exp_next = exp_half;
                    if (exp_half != 31'd0)
                    begin
                        mode_rp_next = 1'b0;
                        state_next   = S_MUL;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mac_valid = 1'b1;
                cmd.mac_first = (k_reg == '0);
                cmd.mac_last  = k_wrap;
                cmd.mac_rp    = mode_rp_reg;
                k_next = k_wrap ? '0 : k_reg + ONE_I;
                if (k_wrap)
                begin
                    j_next = j_wrap ? '0 : j_reg + ONE_I;
                    if (j_wrap)
                    begin
                        i_next = i_wrap ? '0 : i_reg + ONE_I;
                        if (i_wrap)
                        begin
                            cnt_next   = MAC_DRAIN;
                            state_next = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == 4'd1)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_COPY:
            begin
                cmd.copy_valid = 1'b1;
                cmd.copy_to_p  = !mode_rp_reg;
                j_next = j_wrap ? '0 : j_reg + ONE_I;
                if (j_wrap)
                begin
                    i_next = i_wrap ? '0 : i_reg + ONE_I;
                    if (i_wrap)
                    begin
                        if (mode_rp_reg)
                        begin
                            exp_next = {exp_reg[30:1], 1'b0};
                        end
                        state_next = S_CHECK;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_valid = 1'b1;
                cmd.sum_first = (i_reg == '0) && (j_reg == '0);
                j_next = j_wrap ? '0 : j_reg + ONE_I;
                if (j_wrap)
                begin
                    i_next = i_wrap ? '0 : i_reg + ONE_I;
                    if (i_wrap)
                    begin
                        cnt_next   = SUM_DRAIN;
                        state_next = S_SDRAIN;
                    end
                end
            end
            S_SDRAIN:
            begin
                if (cnt_reg == 4'd1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_FIN:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            exp_reg     <= '0;
            m_last_reg  <= '0;
            mode_rp_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            exp_reg     <= exp_next;
            m_last_reg  <= m_last_next;
            mode_rp_reg <= mode_rp_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule

/* rtl/zcmp_datapath.sv */
`include "zigzag_count_matrix_power_top_defines.svh"

module zcmp_datapath
    import zcmp_pkg::*;
#(
    parameter int MAX_VALUES = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  zcmp_cmd_t                     cmd,
    input  logic [$clog2(MAX_VALUES)-1:0] row_idx,
    input  logic [$clog2(MAX_VALUES)-1:0] col_idx,
    input  logic [$clog2(MAX_VALUES)-1:0] inner_idx,
    output zcmp_status_t                  status,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [29:0]                   count_mod_prime
);

    localparam int IW         = $clog2(MAX_VALUES);
    localparam int AW         = 2 * IW;
    localparam int DEPTH      = 1 << AW;
    localparam int MAC_STAGES = 7;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic          rp;
        logic [AW-1:0] waddr;
    } mac_tag_t;

    logic [29:0] mem_r [DEPTH];
    logic [29:0] mem_p [DEPTH];
    logic [29:0] mem_s [DEPTH];

    logic [AW-1:0] addr_ij, addr_ik, addr_kj, r_raddr;
    logic [29:0]   r_rd, pa_rd, pb_rd, s_rd;

    logic          r_we, p_we, s_we;
    logic [AW-1:0] r_waddr, p_waddr;
    logic [29:0]   r_wdata, p_wdata;

    mac_tag_t      tag_reg [MAC_STAGES];
    logic [29:0]   a_op;
    logic [59:0]   prod_reg;
    logic [62:0]   qh_reg;
    logic [31:0]   x3_reg, x4_reg;
    logic [31:0]   qp_reg;
    logic [31:0]   r5_reg, r6_reg;
    logic [29:0]   r7_reg;
    logic [29:0]   acc_reg;
    logic [29:0]   acc_base;
    logic [30:0]   acc_add;
    logic [29:0]   acc_sum;

    logic          cp_v_reg, cp_p_reg;
    logic [AW-1:0] cp_addr_reg;

    logic          sum_v_reg, sum_first_reg;
    logic [29:0]   total_reg;
    logic [29:0]   tot_base;
    logic [30:0]   tot_add;
    logic [29:0]   tot_sum;
    logic [30:0]   dbl_add;
    logic [29:0]   dbl_mod;

    logic          out_valid_reg;
    logic [29:0]   out_data_reg;

    assign addr_ij = {row_idx, col_idx};
    assign addr_ik = {row_idx, inner_idx};
    assign addr_kj = {inner_idx, col_idx};
    assign r_raddr = cmd.sum_valid ? addr_ij : addr_ik;

    // write port selection, init and copy never overlap
    assign r_we    = cmd.init_valid | (cp_v_reg & ~cp_p_reg);
    assign r_waddr = cmd.init_valid ? addr_ij : cp_addr_reg;
    assign r_wdata = cmd.init_valid ? {29'd0, cmd.init_r_one} : s_rd;
    assign p_we    = cmd.init_valid | (cp_v_reg & cp_p_reg);
    assign p_waddr = cmd.init_valid ? addr_ij : cp_addr_reg;
    assign p_wdata = cmd.init_valid ? {29'd0, cmd.init_p_one} : s_rd;
    assign s_we    = tag_reg[MAC_STAGES-1].valid & tag_reg[MAC_STAGES-1].last;

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            mem_r[r_waddr] <= r_wdata;
        end
        r_rd <= mem_r[r_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            mem_p[p_waddr] <= p_wdata;
        end
        pa_rd <= mem_p[addr_ik];
        pb_rd <= mem_p[addr_kj];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            mem_s[tag_reg[MAC_STAGES-1].waddr] <= acc_sum;
        end
        s_rd <= mem_s[addr_ij];
    end

    // mac pipeline: multiply, barrett estimate, q*p, subtract, two corrections
    assign a_op = tag_reg[0].rp ? r_rd : pa_rd;

    always_ff @(posedge clk)
    begin
        prod_reg <= {30'd0, a_op} * {30'd0, pb_rd};
        qh_reg   <= {32'd0, prod_reg[59:29]} * {31'd0, BARRETT_MU};
        x3_reg   <= prod_reg[31:0];
        qp_reg   <= {1'b0, qh_reg[62:32]} * PRIME;
        x4_reg   <= x3_reg;
        r5_reg   <= x4_reg - qp_reg;
        r6_reg   <= (r5_reg >= PRIME) ? r5_reg - PRIME : r5_reg;
        r7_reg   <= (r6_reg >= PRIME) ? 30'(r6_reg - PRIME) : r6_reg[29:0];
        if (tag_reg[MAC_STAGES-1].valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign acc_base = tag_reg[MAC_STAGES-1].first ? 30'd0 : acc_reg;
    assign acc_add  = {1'b0, acc_base} + {1'b0, r7_reg};
    assign acc_sum  = ({1'b0, acc_add} >= PRIME) ? 30'(acc_add - PRIME[30:0]) : acc_add[29:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAC_STAGES; s++)
            begin
                tag_reg[s] <= '0;
            end
            cp_v_reg      <= 1'b0;
            cp_p_reg      <= 1'b0;
            cp_addr_reg   <= '0;
            sum_v_reg     <= 1'b0;
            sum_first_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg[0] <= '{valid: cmd.mac_valid, first: cmd.mac_first,
                            last: cmd.mac_last, rp: cmd.mac_rp, waddr: addr_ij};
            for (int s = 1; s < MAC_STAGES; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            cp_v_reg      <= cmd.copy_valid;
            cp_p_reg      <= cmd.copy_to_p;
            cp_addr_reg   <= addr_ij;
            sum_v_reg     <= cmd.sum_valid;
            sum_first_reg <= cmd.sum_first;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // running sum of the result matrix, and its double for the output
    assign tot_base = sum_first_reg ? 30'd0 : total_reg;
    assign tot_add  = {1'b0, tot_base} + {1'b0, r_rd};
    assign tot_sum  = ({1'b0, tot_add} >= PRIME) ? 30'(tot_add - PRIME[30:0]) : tot_add[29:0];
    assign dbl_add  = {1'b0, total_reg} + {1'b0, total_reg};
    assign dbl_mod  = ({1'b0, dbl_add} >= PRIME) ? 30'(dbl_add - PRIME[30:0]) : dbl_add[29:0];

    always_ff @(posedge clk)
    begin
        if (cmd.total_clear)
        begin
            total_reg <= 30'd0;
        end
        else if (sum_v_reg)
        begin
            total_reg <= tot_sum;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= dbl_mod;
        end
    end

    assign status.out_full = out_valid_reg;
    assign rsp_valid       = out_valid_reg;
    assign count_mod_prime = out_data_reg;

    `ZCMP_ASSERT_IMP(a_mac_residue, tag_reg[MAC_STAGES-1].valid, (r7_reg < PRIME) && (acc_sum < PRIME), "mac residue not reduced")
    `ZCMP_ASSERT_IMP(a_one_writer, 1'b1, $onehot0({cmd.init_valid, cp_v_reg, s_we}), "matrix write sources overlap")
    `ZCMP_ASSERT_NXT(a_sum_range, sum_v_reg, total_reg < PRIME, "running total out of range")
    `ZCMP_ASSERT_NXT(a_out_load, cmd.out_load, out_valid_reg && (out_data_reg < PRIME), "result not presented")

endmodule

/* rtl/zigzag_count_matrix_power_top.sv */
// m = min(value_count, MAX_VALUES), e = array_length - 1:
//   init sweep, then popcount(e) + floor(log2(e)) matrix products, at most 60,
//   each followed by a copy-back, then a final sum sweep
// throughput: one item at a time, set by the single multiply-accumulate pipeline
//   (one product term per cycle) fed from the matrix memories
// reset: asynchronous active low; value_count returns to 2, matrices are not cleared
module zigzag_count_matrix_power_top
    import zcmp_pkg::*;
#(
    parameter int MAX_VALUES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write, always ready
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  value_count,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [30:0] array_length,
    // response channel
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [29:0] count_mod_prime
);

    localparam int IW = $clog2(MAX_VALUES);

    // value count register, saturated to MAX_VALUES inside the controller
    logic [6:0] value_count_reg;

    zcmp_cmd_t     cmd;
    zcmp_status_t  status;
    logic [IW-1:0] row_idx;
    logic [IW-1:0] col_idx;
    logic [IW-1:0] inner_idx;

    assign cfg_ready = 1'b1;

    // a config beat is registered directly into the value count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= 7'd2;
        end
        else if (cfg_valid)
        begin
            value_count_reg <= value_count;
        end
    end

    // sequencer: init sweep, square-and-multiply steps, copy-back, final sum
    zcmp_ctrl #(
        .MAX_VALUES (MAX_VALUES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .array_length (array_length),
        .value_count  (value_count_reg),
        .status       (status),
        .cmd          (cmd),
        .row_idx      (row_idx),
        .col_idx      (col_idx),
        .inner_idx    (inner_idx)
    );

    // matrix memories, modular mac pipeline, sum and output register
    zcmp_datapath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .row_idx         (row_idx),
        .col_idx         (col_idx),
        .inner_idx       (inner_idx),
        .status          (status),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .count_mod_prime (count_mod_prime)
    );

endmodule

/* tb/zigzag_count_matrix_power_checker.sv */
`timescale 1ns / 1ps

module zigzag_count_matrix_power_checker
#(
    parameter int MAX_VALUES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  value_count,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [30:0] array_length,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [29:0] count_mod_prime,
    output int          pending,
    output int          fail_count
);

    localparam longint MODULUS = 64'd1000000007;

    logic [6:0]   shadow_count;
    logic [29:0]  expected_counts[$];
    longint       acc_mat[MAX_VALUES][MAX_VALUES];
    longint       base_mat[MAX_VALUES][MAX_VALUES];
    longint       tmp_mat[MAX_VALUES][MAX_VALUES];

    // acc = acc * base when into_acc, else base = base * base
    function automatic void mat_mult(input int m, input bit into_acc);
        longint s;
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
            begin
                s = 0;
                for (int k = 0; k < m; k++)
                    s = (s + (into_acc ? acc_mat[i][k] : base_mat[i][k]) * base_mat[k][j])
                        % MODULUS;
                tmp_mat[i][j] = s;
            end
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
                if (into_acc)
                    acc_mat[i][j] = tmp_mat[i][j];
                else
                    base_mat[i][j] = tmp_mat[i][j];
    endfunction

    function automatic logic [29:0] zigzag_count(input logic [6:0] cnt, input logic [30:0] len);
        int          m;
        logic [30:0] e;
        longint      total;
        m = (cnt > MAX_VALUES) ? MAX_VALUES : int'(cnt);
        e = (len == 0) ? 31'd0 : len - 31'd1;
        total = 0;
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
            begin
                acc_mat[i][j] = (i == j) ? 1 : 0;
                base_mat[i][j] = (i + j >= m) ? 1 : 0;
            end
        while (e > 0)
        begin
            if (e[0])
                mat_mult(m, 1'b1);
            e = e >> 1;
            if (e > 0)
                mat_mult(m, 1'b0);
        end
        for (int i = 0; i < m; i++)
            for (int j = 0; j < m; j++)
                total = (total + acc_mat[i][j]) % MODULUS;
        return 30'((total * 2) % MODULUS);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [29:0] want;
        if (!rst_n)
        begin
            shadow_count <= 7'd2;
            expected_counts.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                shadow_count <= value_count;
            if (req_valid && !req_stall)
                expected_counts.push_back(zigzag_count(shadow_count, array_length));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("count_mod_prime: unexpected beat, actual %0d", count_mod_prime);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (want !== count_mod_prime)
                    begin
                        $error("count_mod_prime: expected %0d, actual %0d",
                               want, count_mod_prime);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_counts.size();
        end
    end

endmodule

/* tb/zigzag_count_matrix_power_top_tb.sv */
`timescale 1ns / 1ps

module zigzag_count_matrix_power_top_tb;

    // slowest directed item is one 64x64 product, random items stay at m <= 5
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  value_count;
    logic        req_valid;
    logic        req_stall;
    logic [30:0] array_length;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [29:0] count_mod_prime;
    int          pending;
    int          fail_count;
    longint      cycles = 0;
    bit          calm_phase;   // no gaps and no stalls while set

    zigzag_count_matrix_power_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .value_count     (value_count),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .array_length    (array_length),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .count_mod_prime (count_mod_prime)
    );

    zigzag_count_matrix_power_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .value_count     (value_count),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .array_length    (array_length),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .count_mod_prime (count_mod_prime),
        .pending         (pending),
        .fail_count      (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int gap_len();
        if (calm_phase)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    // response-side backpressure, changes at the falling edge
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_phase)
                rsp_stall <= 1'b0;
            else
            begin
                hold = gap_len();
                if (hold > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (hold) @(negedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back beat
    task automatic send_length(input logic [30:0] len);
        int idle;
        idle = gap_len();
        if (idle > 0)
        begin
            req_valid <= 1'b0;
            array_length <= 31'($urandom);
            repeat (idle) @(negedge clk);
        end
        req_valid <= 1'b1;
        array_length <= len;
        // beat taken at the first rising edge with stall low
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    // register write only once everything has drained
    task automatic write_count(input logic [6:0] cnt);
        req_valid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(negedge clk);
        cfg_valid <= 1'b1;
        value_count <= cnt;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] rand_length();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 8));
            1: return 31'($urandom_range(0, 1000));
            default: return 31'($urandom);
        endcase
    endfunction

    initial
    begin
        calm_phase = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        value_count = 7'd0;
        req_valid = 1'b0;
        array_length = 31'd0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value count of 2: zero length, short and longest lengths
        send_length(31'd0);
        send_length(31'd1);
        send_length(31'd2);
        send_length(31'd3);
        send_length(31'h7fffffff);
        send_length(31'h55555555);
        send_length(31'h2aaaaaaa);
        // single value
        write_count(7'd1);
        send_length(31'h7fffffff);
        send_length(31'd0);
        send_length(31'd1);
        // empty matrix gives zero
        write_count(7'd0);
        send_length(31'h7fffffff);
        send_length(31'd5);
        // oversized count saturates, kept to the cheap lengths
        write_count(7'd127);
        send_length(31'd0);
        send_length(31'd1);
        // largest real matrix, at most one product
        write_count(7'd64);
        send_length(31'd1);
        send_length(31'd2);
        write_count(7'd3);
        send_length(31'd4);
        send_length(31'h40000000);

        // random phases over small matrices
        for (int phase = 0; phase < 10; phase++)
        begin
            write_count(7'($urandom_range(0, 5)));
            calm_phase = (phase % 4 == 3);
            for (int k = 0; k < 10; k++)
                send_length(rand_length());
            calm_phase = 1'b0;
        end
        req_valid <= 1'b0;

        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
